// ----- sv/address_range_coalescer_unit_defines.svh -----
// Assertion macros for the verification file of the range coalescer.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef ADDRESS_RANGE_COALESCER_UNIT_DEFINES_SVH
`define ADDRESS_RANGE_COALESCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ARC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ARC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/arc_pkg.sv -----
// Shared types and constants of the address range coalescer.
// No dependencies; used by the sequencer and the top level.
package arc_pkg;

    localparam int MAX_RANGES = 64;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int OCT_W      = 8;
    localparam int ENTRY_W    = 3 * OCT_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef struct packed {
        logic [OCT_W-1:0] subnet;
        logic [OCT_W-1:0] first;
        logic [OCT_W-1:0] last;
    } t_entry;

    // One dump word handed from the sequencer to the output register.
    typedef struct packed {
        logic   load;
        t_entry entry;
        logic   final_entry;
        logic   overflowed;
    } t_emit;

endpackage

// ----- sv/arc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/arc_seq.sv -----
// Coalescer sequencer: scans the range RAM one entry per cycle; dumps can stall.
// Depends on arc_pkg; drives the ports of one arc_ram instance.
module arc_seq
    import arc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic [OCT_W-1:0]   i_subnet_octet,
    input  logic [OCT_W-1:0]   i_host_octet,
    input  logic               i_out_free,
    output t_emit              o_emit,
    output logic               o_wr_en,
    output logic [IDX_W-1:0]   o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data,
    output logic [IDX_W-1:0]   o_rd_addr,
    input  logic [ENTRY_W-1:0] i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_INSERT = 3'b010,
        S_DUMP   = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_overflow, n_overflow;
    logic [OCT_W-1:0] r_subnet, n_subnet;
    logic [OCT_W-1:0] r_host, n_host;

    t_entry           rd_entry;
    t_entry           wr_entry;
    logic             last_idx;
    logic             full;
    logic             sub_hit;
    logic             grow_down;
    logic             grow_up;

    assign rd_entry  = t_entry'(i_rd_data);
    assign last_idx  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign full      = r_count == CNT_W'(MAX_RANGES);
    assign sub_hit   = rd_entry.subnet == r_subnet;
    // Both tests are done one bit wider so that 0 and 255 never wrap.
    assign grow_down = sub_hit &&
                       ({1'b0, rd_entry.first} == ({1'b0, r_host} + (OCT_W+1)'(1)));
    assign grow_up   = sub_hit &&
                       (({1'b0, rd_entry.last} + (OCT_W+1)'(1)) == {1'b0, r_host});

    assign o_ready   = r_state == S_IDLE;
    assign o_wr_data = wr_entry;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_subnet   = r_subnet;
        n_host     = r_host;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_count[IDX_W-1:0];
        wr_entry   = '{subnet: r_subnet, first: r_host, last: r_host};
        o_rd_addr  = r_idx;
        o_emit     = '0;

        unique case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                if (i_valid) begin
                    n_subnet = i_subnet_octet;
                    n_host   = i_host_octet;
                    n_idx    = '0;
                    if (i_operation == OP_INSERT) begin
                        if (r_count == '0) begin
                            // Empty table: the first range is written at once.
                            o_wr_en   = 1'b1;
                            o_wr_addr = '0;
                            wr_entry  = '{subnet: i_subnet_octet, first: i_host_octet,
                                          last: i_host_octet};
                            n_count   = CNT_W'(1);
                        end else begin
                            n_state = S_INSERT;
                        end
                    end else if (r_count != '0) begin
                        n_state = S_DUMP;
                    end
                end
            end
            S_INSERT: begin
                // Entry r_idx is on the read port; fetch the next one meanwhile.
                o_rd_addr = r_idx + IDX_W'(1);
                priority if (grow_down) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx;
                    wr_entry  = '{subnet: rd_entry.subnet, first: r_host,
                                  last: rd_entry.last};
                    n_state   = S_IDLE;
                end else if (grow_up) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx;
                    wr_entry  = '{subnet: rd_entry.subnet, first: rd_entry.first,
                                  last: r_host};
                    n_state   = S_IDLE;
                end else if (last_idx) begin
                    if (full) begin
                        n_overflow = 1'b1;
                    end else begin
                        o_wr_en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DUMP: begin
                if (i_out_free) begin
                    o_emit.load        = 1'b1;
                    o_emit.entry       = rd_entry;
                    o_emit.final_entry = last_idx;
                    o_emit.overflowed  = r_overflow;
                    if (last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx     = r_idx + IDX_W'(1);
                        o_rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_subnet <= n_subnet;
        r_host   <= n_host;
    end

endmodule

// ----- sv/address_range_coalescer_unit.sv -----
// Address range coalescer: a table of host ranges per subnet, kept in one RAM.
// Depends on arc_pkg, arc_ram and arc_seq.
//
// Usage. The input channel (i_valid / o_ready) carries one word per command:
// an insert of a subnet and host octet, or a dump of the whole table. The
// output channel (o_valid / i_ready) carries one word per stored range during
// a dump, in insertion order, with o_final_entry set on the last word and
// o_overflowed showing whether any insert was ever dropped for lack of room.
// Inserts produce no output word, and a dump of an empty table produces none.
//
// Operation. The ranges live in a RAM with one read port, and the sequencer
// compares one entry per cycle. An insert into an empty table is written at
// once; otherwise the sequencer scans the stored entries until one can be
// extended, and appends a new range if none can. A dump reads the entries in
// turn and pauses while the receiver stalls. A new command is accepted as
// soon as the previous one has finished, even while the last dump word still
// waits in the output register.
//
// Reset clears the range count, the overflow flag and the output valid bit.
// The RAM itself is not cleared; only entries below the count are used. When
// the receiver stalls, the dump pauses and the waiting word holds steady.
module address_range_coalescer_unit
    import arc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_operation,
    input  logic [OCT_W-1:0] i_subnet_octet,
    input  logic [OCT_W-1:0] i_host_octet,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OCT_W-1:0] o_range_subnet,
    output logic [OCT_W-1:0] o_range_first,
    output logic [OCT_W-1:0] o_range_last,
    output logic             o_final_entry,
    output logic             o_overflowed
);

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    t_emit              emit;
    logic               out_free;

    logic               r_out_valid;
    t_entry             r_out_entry;
    logic               r_out_final;
    logic               r_out_ovf;

    // The output register can take a new word when it is empty or being drained.
    assign out_free = !r_out_valid || i_ready;

    arc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    arc_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_subnet_octet (i_subnet_octet),
        .i_host_octet   (i_host_octet),
        .i_out_free     (out_free),
        .o_emit         (emit),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            r_out_entry <= emit.entry;
            r_out_final <= emit.final_entry;
            r_out_ovf   <= emit.overflowed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_range_subnet = r_out_entry.subnet;
    assign o_range_first  = r_out_entry.first;
    assign o_range_last   = r_out_entry.last;
    assign o_final_entry  = r_out_final;
    assign o_overflowed   = r_out_ovf;

endmodule

// ----- sv/arc_checker.sv -----
// Port-level checks of the address range coalescer, bound to the top level.
// Depends on address_range_coalescer_unit_defines.svh.
`include "address_range_coalescer_unit_defines.svh"

module arc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_operation,
    input logic [7:0] i_subnet_octet,
    input logic [7:0] i_host_octet,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_range_subnet,
    input logic [7:0] o_range_first,
    input logic [7:0] o_range_last,
    input logic       o_final_entry,
    input logic       o_overflowed
);

    // A stalled output word keeps its contents.
    `ARC_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_range_subnet) && $stable(o_range_first) && $stable(o_range_last) && $stable(o_final_entry), "stalled output word changed")

    // No new command is taken while a dump is still in progress.
    `ARC_ASSERT_IMP(a_busy_in_dump, o_valid && !o_final_entry, !o_ready, "command accepted in the middle of a dump")

    // A dump streams without gaps when the receiver keeps taking words.
    `ARC_ASSERT_NXT(a_dump_no_gap, o_valid && !o_final_entry && i_ready, o_valid, "gap inside a dump")

    // The overflow indication never falls back once it has been shown.
    `ARC_ASSERT_NXT(a_ovf_sticky, o_valid && o_overflowed, o_overflowed, "overflow flag cleared")

endmodule

bind address_range_coalescer_unit arc_checker u_arc_checker (.*);
